### design/lcs_pkg.sv
// shared constants and payload types for the linear congruence solver
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int LCS_W = 32;
    localparam int LCS_CNT_W = $clog2(LCS_W);

    typedef struct packed {
        logic signed [LCS_W-1:0] coef_a;
        logic [LCS_W-2:0]        modulus;
        logic signed [LCS_W-1:0] rhs_c;
    } t_lcs_in;

    typedef struct packed {
        logic             solvable;
        logic [LCS_W-2:0] least_x;
    } t_lcs_out;

endpackage

### design/lcs_modadd.sv
// shared add, compare and conditional subtract unit: (x + y + cin) reduced once by mod
`timescale 1ns / 1ps

module lcs_modadd import lcs_pkg::*; (
    input  logic [LCS_W:0]   i_x,
    input  logic [LCS_W:0]   i_y,
    input  logic             i_cin,
    input  logic [LCS_W-1:0] i_mod,
    output logic [LCS_W:0]   o_res,
    output logic             o_ge
);

    logic [LCS_W+1:0] sum;
    logic [LCS_W+1:0] diff;

    always_comb begin
        sum   = {1'b0, i_x} + {1'b0, i_y} + (LCS_W+2)'(i_cin);
        diff  = sum - {2'b00, i_mod};
        o_ge  = (sum >= {2'b00, i_mod});
        o_res = o_ge ? diff[LCS_W:0] : sum[LCS_W:0];
    end

endmodule

### design/linear_congruence_solver_unit.sv
// top level: solves a*x = c (mod m) with an extended euclid sequencer on one shared unit
`timescale 1ns / 1ps

// Solves a*x = c (mod m) for one item at a time. The gcd g of |a| and m comes
// from the extended Euclidean algorithm, whose Bezout coefficient gives the
// inverse of a/g modulo m/g; the result is the least x in [0, m/g), or
// solvable = 0 with least_x = 0 when g does not divide c or m is zero.
// Every step runs on one shared add/compare/subtract unit: each division is a
// restoring divide, one quotient bit per cycle, and the final modular product
// is formed by double and add. An item with no solution stops after the gcd
// check, and a zero modulus goes straight to the result. A full output
// register holds the sequencer in its done state until it is read.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register, so a new item may be taken before the last one is read.

module linear_congruence_solver_unit import lcs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lcs_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_lcs_out o_out
);

    localparam int TW = LCS_W + 2;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_EUC_TEST = 11'b00000000010,
        S_EUC_DIV  = 11'b00000000100,
        S_CHK_DIV  = 11'b00000001000,
        S_MR_DIV   = 11'b00000010000,
        S_CR_DIV   = 11'b00000100000,
        S_INV_DIV  = 11'b00001000000,
        S_NEG      = 11'b00010000000,
        S_MUL_DBL  = 11'b00100000000,
        S_MUL_ADD  = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [LCS_CNT_W-1:0] r_cnt, n_cnt;
    logic r_a_neg, n_a_neg;
    logic r_c_neg, n_c_neg;
    logic [LCS_W-1:0] r_c_mag, n_c_mag;
    logic [LCS_W-2:0] r_m, n_m;
    logic [LCS_W-1:0] r_r0, n_r0;
    logic [LCS_W-1:0] r_r1, n_r1;
    logic signed [TW-1:0] r_t0, n_t0;
    logic signed [TW-1:0] r_t1, n_t1;
    logic signed [TW-1:0] r_tacc, n_tacc;
    logic [LCS_W-1:0] r_dvd, n_dvd;
    logic [LCS_W-1:0] r_dvs, n_dvs;
    logic [LCS_W:0]   r_rem, n_rem;
    logic [LCS_W-1:0] r_cq, n_cq;
    logic [LCS_W-2:0] r_mr, n_mr;
    logic [LCS_W-2:0] r_cr, n_cr;
    logic [LCS_W-2:0] r_inv, n_inv;
    logic r_sol, n_sol;
    logic [LCS_W-2:0] r_x, n_x;
    logic r_out_valid, n_out_valid;
    t_lcs_out r_out, n_out;

    logic [LCS_W:0]   u_x, u_y;
    logic             u_cin;
    logic [LCS_W:0]   u_res;
    logic             u_ge;

    logic                 div_last;
    logic                 mul_last;
    logic [LCS_W-1:0]     quot;
    logic signed [TW-1:0] tacc_step;
    logic signed [TW-1:0] t0_abs;
    logic [LCS_W-1:0]     a_in_mag;
    logic [LCS_W-1:0]     c_in_mag;

    lcs_modadd u_modadd (
        .i_x   (u_x),
        .i_y   (u_y),
        .i_cin (u_cin),
        .i_mod (r_dvs),
        .o_res (u_res),
        .o_ge  (u_ge)
    );

    // operand select for the shared unit
    always_comb begin
        u_x   = r_rem;
        u_y   = r_rem;
        u_cin = 1'b0;
        unique case (r_state)
            S_EUC_DIV, S_CHK_DIV, S_MR_DIV, S_CR_DIV, S_INV_DIV: begin
                u_cin = r_dvd[LCS_W-1];
            end
            S_MUL_ADD: begin
                u_y = {2'b00, r_cr};
            end
            default: begin
                u_cin = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_last  = (r_cnt == LCS_CNT_W'(LCS_W-1));
        mul_last  = (r_cnt == LCS_CNT_W'(LCS_W-2));
        quot      = {r_dvd[LCS_W-2:0], u_ge};
        // running q * t1, built msb first alongside the quotient bits
        tacc_step = (r_tacc <<< 1) + (u_ge ? r_t1 : TW'(0));
        t0_abs    = r_t0[TW-1] ? -r_t0 : r_t0;
        a_in_mag  = i_in.coef_a[LCS_W-1] ? -i_in.coef_a : i_in.coef_a;
        c_in_mag  = i_in.rhs_c[LCS_W-1] ? -i_in.rhs_c : i_in.rhs_c;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_a_neg     = r_a_neg;
        n_c_neg     = r_c_neg;
        n_c_mag     = r_c_mag;
        n_m         = r_m;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_tacc      = r_tacc;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_cq        = r_cq;
        n_mr        = r_mr;
        n_cr        = r_cr;
        n_inv       = r_inv;
        n_sol       = r_sol;
        n_x         = r_x;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        // division step, used by every divide state
        if ((r_state == S_EUC_DIV) || (r_state == S_CHK_DIV) || (r_state == S_MR_DIV) ||
            (r_state == S_CR_DIV) || (r_state == S_INV_DIV)) begin
            n_rem  = u_res;
            n_dvd  = quot;
            n_tacc = tacc_step;
            n_cnt  = r_cnt + LCS_CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a_neg = i_in.coef_a[LCS_W-1];
                    n_c_neg = i_in.rhs_c[LCS_W-1];
                    n_c_mag = c_in_mag;
                    n_m     = i_in.modulus;
                    n_r0    = {1'b0, i_in.modulus};
                    n_r1    = a_in_mag;
                    n_t0    = '0;
                    n_t1    = TW'(1);
                    if (i_in.modulus == '0) begin
                        n_sol   = 1'b0;
                        n_x     = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_EUC_TEST;
                    end
                end
            end
            S_EUC_TEST: begin
                n_rem  = '0;
                n_cnt  = '0;
                n_tacc = '0;
                if (r_r1 == '0) begin
                    // r0 now holds g, t0 the coefficient of |a|
                    n_dvd   = r_c_mag;
                    n_dvs   = r_r0;
                    n_state = S_CHK_DIV;
                end else begin
                    n_dvd   = r_r0;
                    n_dvs   = r_r1;
                    n_state = S_EUC_DIV;
                end
            end
            S_EUC_DIV: begin
                if (div_last) begin
                    n_r0    = r_r1;
                    n_r1    = u_res[LCS_W-1:0];
                    n_t0    = r_t1;
                    n_t1    = r_t0 - tacc_step;
                    n_state = S_EUC_TEST;
                end
            end
            S_CHK_DIV: begin
                if (div_last) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (u_res != '0) begin
                        n_sol   = 1'b0;
                        n_x     = '0;
                        n_state = S_DONE;
                    end else begin
                        n_cq    = quot;
                        n_dvd   = {1'b0, r_m};
                        n_state = S_MR_DIV;
                    end
                end
            end
            S_MR_DIV: begin
                if (div_last) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_mr    = quot[LCS_W-2:0];
                    n_dvd   = r_cq;
                    n_dvs   = {1'b0, quot[LCS_W-2:0]};
                    n_state = S_CR_DIV;
                end
            end
            S_CR_DIV: begin
                if (div_last) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_cr    = u_res[LCS_W-2:0];
                    n_dvd   = t0_abs[LCS_W-1:0];
                    n_state = S_INV_DIV;
                end
            end
            S_INV_DIV: begin
                if (div_last) begin
                    n_inv   = u_res[LCS_W-2:0];
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                // fold signs of c and of the inverse back into residues
                if (r_c_neg && (r_cr != '0)) begin
                    n_cr = r_mr - r_cr;
                end
                if ((r_t0[TW-1] ^ r_a_neg) && (r_inv != '0)) begin
                    n_inv = r_mr - r_inv;
                end
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_MUL_DBL;
            end
            S_MUL_DBL: begin
                n_rem   = u_res;
                n_state = S_MUL_ADD;
            end
            S_MUL_ADD: begin
                if (r_inv[LCS_W-2]) begin
                    n_rem = u_res;
                end
                n_inv = r_inv << 1;
                n_cnt = r_cnt + LCS_CNT_W'(1);
                if (mul_last) begin
                    n_sol   = 1'b1;
                    n_x     = r_inv[LCS_W-2] ? u_res[LCS_W-2:0] : r_rem[LCS_W-2:0];
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_DBL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.solvable   = r_sol;
                    n_out.least_x    = r_x;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg <= n_a_neg;
        r_c_neg <= n_c_neg;
        r_c_mag <= n_c_mag;
        r_m     <= n_m;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_tacc  <= n_tacc;
        r_dvd   <= n_dvd;
        r_dvs   <= n_dvs;
        r_rem   <= n_rem;
        r_cq    <= n_cq;
        r_mr    <= n_mr;
        r_cr    <= n_cr;
        r_inv   <= n_inv;
        r_sol   <= n_sol;
        r_x     <= n_x;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
